// ===== rtl/fwpid_pkg.sv =====
// Shared constants and types for the four-wheel PID speed controller.
package fwpid_pkg;

  localparam int WHEELS         = 4;
  localparam int WHEEL_W        = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int SPEED_W = 17;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int SUM_W   = 32;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int DRIVE_W = 16;

  localparam int P_W   = ERR_W + GAIN_W + 1;
  localparam int D_W   = DIFF_W + GAIN_W + 1;
  localparam int I_W   = SUM_W + GAIN_W + 1;
  localparam int TOT_W = I_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd7680;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 16'd1280;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 16'd2560;
  localparam logic [GAIN_W-1:0] INTEG_LIMIT_RST = 16'd8000;
  localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST = 15'd9500;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;

endpackage

// ===== rtl/four_wheel_pid_speed_control.sv =====
// Four-wheel PID speed controller: wheel sequencer, state memory and datapath.
// Wheels go one per cycle, while the output is not stalled, through the shared datapath
//   and the one read and one write port of the per-wheel state memory; a new item is
//   accepted as the last wheel of the previous one leaves the sequencer.
// Reset: gains and limits return to their defaults, per-wheel error history and
//   integral read as zero until written, the channels come up empty.
module four_wheel_pid_speed_control
  import fwpid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  speed_t                in_speed_meas_0,
  input  speed_t                in_speed_meas_1,
  input  speed_t                in_speed_meas_2,
  input  speed_t                in_speed_meas_3,
  input  speed_t                in_speed_goal_0,
  input  speed_t                in_speed_goal_1,
  input  speed_t                in_speed_goal_2,
  input  speed_t                in_speed_goal_3,
  output logic                  out_valid,
  input  logic                  out_stall,
  output drive_t                out_drive_0,
  output drive_t                out_drive_1,
  output drive_t                out_drive_2,
  output drive_t                out_drive_3,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r, integ_limit_r;
  logic [LIM_W-1:0]  drive_limit_r;

  speed_t             meas_buf_r [WHEELS];
  speed_t             goal_buf_r [WHEELS];
  logic               busy_r;
  logic [WHEEL_W-1:0] wheel_r;

  err_t               mem_err [WHEELS];
  sum_t               mem_sum [WHEELS];
  logic [WHEELS-1:0]  mem_vld_r;
  err_t               rd_err_r;
  sum_t               rd_sum_r;

  logic               s1_v_r, s1_last_r, s1_pos_r;
  logic [WHEEL_W-1:0] s1_w_r;
  err_t               s1_err_r;

  logic               s2_v_r, s2_last_r, s2_pos_r;
  logic [WHEEL_W-1:0] s2_w_r;
  err_t               s2_err_r;
  logic signed [DIFF_W-1:0] s2_diff_r;
  sum_t               s2_sum_r;

  logic               s3_v_r, s3_last_r, s3_pos_r;
  logic [WHEEL_W-1:0] s3_w_r;
  logic signed [P_W-1:0] s3_p_r;
  logic signed [D_W-1:0] s3_d_r;
  logic signed [I_W-1:0] s3_i_r;

  logic               s4_v_r, s4_last_r, s4_pos_r;
  logic [WHEEL_W-1:0] s4_w_r;
  logic signed [TOT_W-1:0] s4_tot_r;

  drive_t             asm_r [WHEELS];
  drive_t             out_r [WHEELS];
  logic               out_valid_r;

  logic               adv, s0_last, accept;
  speed_t             s0_meas, s0_goal;
  err_t               s0_err;
  logic               s0_pos;
  logic signed [SUM_W:0]    s1_sum_ext;
  sum_t               s1_sum;
  logic signed [DIFF_W-1:0] s1_diff;
  logic signed [P_W-1:0]    p_sh;
  logic signed [D_W-1:0]    d_sh;
  logic signed [I_W-1:0]    i_sh, i_cl, i_lim;
  logic signed [TOT_W-1:0]  tot, drv_val, lim_ext;
  drive_t             drv;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid_r && out_stall);
  assign s0_last   = (wheel_r == WHEEL_W'(WHEELS - 1));
  assign in_stall  = busy_r && !(adv && s0_last);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= PROP_GAIN_RST;
      integ_gain_r  <= INTEG_GAIN_RST;
      deriv_gain_r  <= DERIV_GAIN_RST;
      integ_limit_r <= INTEG_LIMIT_RST;
      drive_limit_r <= DRIVE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:   prop_gain_r   <= cfg_data;
        REG_INTEG_GAIN:  integ_gain_r  <= cfg_data;
        REG_DERIV_GAIN:  deriv_gain_r  <= cfg_data;
        REG_INTEG_LIMIT: integ_limit_r <= cfg_data;
        REG_DRIVE_LIMIT: drive_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Input buffer and wheel sequencer
  always_ff @(posedge clk) begin
    if (accept) begin
      meas_buf_r[0] <= in_speed_meas_0;
      meas_buf_r[1] <= in_speed_meas_1;
      meas_buf_r[2] <= in_speed_meas_2;
      meas_buf_r[3] <= in_speed_meas_3;
      goal_buf_r[0] <= in_speed_goal_0;
      goal_buf_r[1] <= in_speed_goal_1;
      goal_buf_r[2] <= in_speed_goal_2;
      goal_buf_r[3] <= in_speed_goal_3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      wheel_r <= '0;
    end else if (accept) begin
      busy_r  <= 1'b1;
      wheel_r <= '0;
    end else if (adv && busy_r) begin
      if (s0_last) begin
        busy_r <= 1'b0;
      end else begin
        wheel_r <= wheel_r + 1'b1;
      end
    end
  end

  always_comb begin
    s0_meas = meas_buf_r[wheel_r];
    s0_goal = goal_buf_r[wheel_r];
    s0_err  = {s0_goal[SPEED_W-1], s0_goal} - {s0_meas[SPEED_W-1], s0_meas};
    s0_pos  = !s0_goal[SPEED_W-1] && (s0_goal != '0);
  end

  // State memory: read in stage 0, write back in stage 1, forward on same wheel
  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      mem_err[s1_w_r] <= s1_err_r;
      mem_sum[s1_w_r] <= s1_sum;
    end
    if (adv && busy_r) begin
      if (s1_v_r && (s1_w_r == wheel_r)) begin
        rd_err_r <= s1_err_r;
        rd_sum_r <= s1_sum;
      end else if (!mem_vld_r[wheel_r]) begin
        rd_err_r <= '0;
        rd_sum_r <= '0;
      end else begin
        rd_err_r <= mem_err[wheel_r];
        rd_sum_r <= mem_sum[wheel_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
    end else if (adv && s1_v_r) begin
      mem_vld_r[s1_w_r] <= 1'b1;
    end
  end

  always_comb begin
    s1_sum_ext = {rd_sum_r[SUM_W-1], rd_sum_r}
               + {{(SUM_W+1-ERR_W){s1_err_r[ERR_W-1]}}, s1_err_r};
    if (s1_sum_ext[SUM_W] != s1_sum_ext[SUM_W-1]) begin
      s1_sum = s1_sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      s1_sum = s1_sum_ext[SUM_W-1:0];
    end
    s1_diff = {s1_err_r[ERR_W-1], s1_err_r} - {rd_err_r[ERR_W-1], rd_err_r};
  end

  always_comb begin
    p_sh    = s3_p_r >>> GAIN_FRAC_BITS;
    d_sh    = s3_d_r >>> GAIN_FRAC_BITS;
    i_sh    = s3_i_r >>> GAIN_FRAC_BITS;
    i_lim   = $signed({{(I_W-GAIN_W){1'b0}}, integ_limit_r});
    i_cl    = (i_sh > i_lim) ? i_lim : i_sh;
    tot     = {{(TOT_W-P_W){p_sh[P_W-1]}}, p_sh}
            + {{(TOT_W-D_W){d_sh[D_W-1]}}, d_sh}
            + {{(TOT_W-I_W){i_cl[I_W-1]}}, i_cl};
    drv_val = s4_pos_r ? s4_tot_r : -s4_tot_r;
    lim_ext = $signed({{(TOT_W-LIM_W){1'b0}}, drive_limit_r});
    if (drv_val > lim_ext) begin
      drv = DRIVE_W'(lim_ext);
    end else if (drv_val < -lim_ext) begin
      drv = DRIVE_W'(-lim_ext);
    end else begin
      drv = drv_val[DRIVE_W-1:0];
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= busy_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_w_r    <= wheel_r;
      s1_last_r <= s0_last;
      s1_pos_r  <= s0_pos;
      s1_err_r  <= s0_err;

      s2_w_r    <= s1_w_r;
      s2_last_r <= s1_last_r;
      s2_pos_r  <= s1_pos_r;
      s2_err_r  <= s1_err_r;
      s2_diff_r <= s1_diff;
      s2_sum_r  <= s1_sum;

      s3_w_r    <= s2_w_r;
      s3_last_r <= s2_last_r;
      s3_pos_r  <= s2_pos_r;
      s3_p_r    <= {{(P_W-ERR_W){s2_err_r[ERR_W-1]}}, s2_err_r}
                 * $signed({{(P_W-GAIN_W){1'b0}}, prop_gain_r});
      s3_d_r    <= {{(D_W-DIFF_W){s2_diff_r[DIFF_W-1]}}, s2_diff_r}
                 * $signed({{(D_W-GAIN_W){1'b0}}, deriv_gain_r});
      s3_i_r    <= {{(I_W-SUM_W){s2_sum_r[SUM_W-1]}}, s2_sum_r}
                 * $signed({{(I_W-GAIN_W){1'b0}}, integ_gain_r});

      s4_w_r    <= s3_w_r;
      s4_last_r <= s3_last_r;
      s4_pos_r  <= s3_pos_r;
      s4_tot_r  <= tot;
    end
  end

  // Assemble wheel results and hold the finished item
  always_ff @(posedge clk) begin
    if (adv && s4_v_r) begin
      if (s4_last_r) begin
        for (int k = 0; k < WHEELS; k++) begin
          out_r[k] <= (s4_w_r == WHEEL_W'(k)) ? drv : asm_r[k];
        end
      end else begin
        asm_r[s4_w_r] <= drv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s4_v_r && s4_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive_0 = out_r[0];
  assign out_drive_1 = out_r[1];
  assign out_drive_2 = out_r[2];
  assign out_drive_3 = out_r[3];

endmodule

// ===== tb/fwpid_drive_checker.sv =====
// Checker for the four-wheel PID speed controller: predicts each drive set and compares it.
module fwpid_drive_checker
  import fwpid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  speed_t                in_speed_meas_0,
  input  speed_t                in_speed_meas_1,
  input  speed_t                in_speed_meas_2,
  input  speed_t                in_speed_meas_3,
  input  speed_t                in_speed_goal_0,
  input  speed_t                in_speed_goal_1,
  input  speed_t                in_speed_goal_2,
  input  speed_t                in_speed_goal_3,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  drive_t                out_drive_0,
  input  drive_t                out_drive_1,
  input  drive_t                out_drive_2,
  input  drive_t                out_drive_3,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef logic [WHEELS-1:0][SPEED_W-1:0] speed_vec_t;
  typedef logic [WHEELS-1:0][DRIVE_W-1:0] drive_vec_t;

  longint     prop_gain_q;
  longint     integ_gain_q;
  longint     deriv_gain_q;
  longint     integ_limit_q;
  longint     drive_limit_q;
  longint     last_err [WHEELS];
  longint     err_acc [WHEELS];
  drive_vec_t drive_sets [$];

  task automatic report(input string what);
    $display("[%0t] drive mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_state();
    prop_gain_q   = PROP_GAIN_RST;
    integ_gain_q  = INTEG_GAIN_RST;
    deriv_gain_q  = DERIV_GAIN_RST;
    integ_limit_q = INTEG_LIMIT_RST;
    drive_limit_q = DRIVE_LIMIT_RST;
    for (int w = 0; w < WHEELS; w++) begin
      last_err[w] = 0;
      err_acc[w]  = 0;
    end
    drive_sets.delete();
  endtask

  task automatic step_wheels(input speed_vec_t meas, input speed_vec_t goal,
                             output drive_vec_t drv);
    longint goal_v, meas_v, err, acc, p_term, d_term, i_term, total;
    for (int w = 0; w < WHEELS; w++) begin
      goal_v = $signed(goal[w]);
      meas_v = $signed(meas[w]);
      err    = goal_v - meas_v;
      acc    = err_acc[w] + err;
      if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
      if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
      err_acc[w] = acc;
      i_term = (acc * integ_gain_q) >>> GAIN_FRAC_BITS;
      if (i_term > integ_limit_q) i_term = integ_limit_q;
      p_term = (err * prop_gain_q) >>> GAIN_FRAC_BITS;
      d_term = ((err - last_err[w]) * deriv_gain_q) >>> GAIN_FRAC_BITS;
      last_err[w] = err;
      total = p_term + d_term + i_term;
      if (goal_v <= 0) total = -total;
      if (total > drive_limit_q) total = drive_limit_q;
      if (total < -drive_limit_q) total = -drive_limit_q;
      drv[w] = total[DRIVE_W-1:0];
    end
  endtask

  always @(posedge clk) begin
    speed_vec_t meas, goal;
    drive_vec_t drv, got, want;
    if (!rst_n) begin
      clear_state();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:   prop_gain_q   = cfg_data;
          REG_INTEG_GAIN:  integ_gain_q  = cfg_data;
          REG_DERIV_GAIN:  deriv_gain_q  = cfg_data;
          REG_INTEG_LIMIT: integ_limit_q = cfg_data;
          REG_DRIVE_LIMIT: drive_limit_q = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        meas = {in_speed_meas_3, in_speed_meas_2, in_speed_meas_1, in_speed_meas_0};
        goal = {in_speed_goal_3, in_speed_goal_2, in_speed_goal_1, in_speed_goal_0};
        step_wheels(meas, goal, drv);
        drive_sets.push_back(drv);
      end
      if (out_valid && !out_stall) begin
        got = {out_drive_3, out_drive_2, out_drive_1, out_drive_0};
        if (drive_sets.size() == 0) begin
          report("drive set with nothing pending");
        end else begin
          want = drive_sets.pop_front();
          for (int w = 0; w < WHEELS; w++)
            if (got[w] != want[w])
              report($sformatf("drive_%0d got %0d, want %0d", w,
                               $signed(got[w]), $signed(want[w])));
        end
      end
    end
    outstanding <= drive_sets.size();
  end

endmodule

// ===== tb/tb_four_wheel_pid_speed_control.sv =====
// Testbench top for the four-wheel PID speed controller: stimulus, watchdog and verdict.
module tb_four_wheel_pid_speed_control;
  import fwpid_pkg::*;

  typedef logic [WHEELS-1:0][SPEED_W-1:0] speed_vec_t;

  localparam int QUIET_LIMIT = 2000;
  localparam int IDLE_PCT    = 29;
  localparam int SOAK_ITEMS  = 124;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = CFG_IDX_W'(REG_DRIVE_LIMIT + 1);
  localparam logic [CFG_IDX_W-1:0] LAST_SPARE_REG  = {CFG_IDX_W{1'b1}};
  localparam logic [CFG_DATA_W-1:0] ALL_ONES       = {CFG_DATA_W{1'b1}};
  localparam speed_t SPEED_TOP    = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam speed_t SPEED_FLOOR  = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam speed_t SPEED_BOTTOM = SPEED_FLOOR + speed_t'(1);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  speed_t                in_speed_meas_0 = '0;
  speed_t                in_speed_meas_1 = '0;
  speed_t                in_speed_meas_2 = '0;
  speed_t                in_speed_meas_3 = '0;
  speed_t                in_speed_goal_0 = '0;
  speed_t                in_speed_goal_1 = '0;
  speed_t                in_speed_goal_2 = '0;
  speed_t                in_speed_goal_3 = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  drive_t                out_drive_0;
  drive_t                out_drive_1;
  drive_t                out_drive_2;
  drive_t                out_drive_3;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;
  int                    quiet_cycles = 0;
  bit                    steady = 1'b0;

  four_wheel_pid_speed_control u_dut (.*);

  fwpid_drive_checker u_check (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(input speed_vec_t meas, input speed_vec_t goal);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_speed_meas_0 <= meas[0];
    in_speed_meas_1 <= meas[1];
    in_speed_meas_2 <= meas[2];
    in_speed_meas_3 <= meas[3];
    in_speed_goal_0 <= goal[0];
    in_speed_goal_1 <= goal[1];
    in_speed_goal_2 <= goal[2];
    in_speed_goal_3 <= goal[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_same(input speed_t meas, input speed_t goal);
    send_item({WHEELS{meas}}, {WHEELS{goal}});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] prop, integ, deriv,
                              input logic [CFG_DATA_W-1:0] integ_lim, drive_lim,
                              input bit spares);
    write_reg(REG_PROP_GAIN, prop);
    if (spares)
      write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
                CFG_DATA_W'($urandom));
    write_reg(REG_INTEG_GAIN, integ);
    write_reg(REG_DERIV_GAIN, deriv);
    write_reg(REG_INTEG_LIMIT, integ_lim);
    write_reg(REG_DRIVE_LIMIT, drive_lim);
    if (spares)
      write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic program_random(input bit spares);
    program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                 CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), spares);
  endtask

  function automatic speed_t rand_speed();
    case ($urandom_range(0, 4))
      0: rand_speed = speed_t'($urandom);
      1: rand_speed = speed_t'(int'($urandom_range(0, 600)) - 300);
      2: begin
        case ($urandom_range(0, 5))
          0: rand_speed = SPEED_FLOOR;
          1: rand_speed = SPEED_BOTTOM;
          2: rand_speed = SPEED_TOP;
          3: rand_speed = speed_t'(-1);
          4: rand_speed = speed_t'(1);
          default: rand_speed = '0;
        endcase
      end
      3: rand_speed = speed_t'(int'($urandom_range(0, 20000)) - 10000);
      default: rand_speed = speed_t'(int'($urandom_range(0, 131070)) - 65535);
    endcase
  endfunction

  task automatic random_run(input int count);
    speed_vec_t meas, goal;
    for (int k = 0; k < count; k++) begin
      for (int w = 0; w < WHEELS; w++) begin
        goal[w] = rand_speed();
        if ($urandom_range(0, 1) == 1)
          meas[w] = goal[w] + speed_t'($urandom_range(0, 400)) - speed_t'(200);
        else
          meas[w] = rand_speed();
      end
      if ($urandom_range(0, 99) == 0) drain();
      send_item(meas, goal);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_same('0, '0);
    send_same(SPEED_BOTTOM, SPEED_TOP);
    send_same(SPEED_TOP, SPEED_BOTTOM);
    send_same(SPEED_TOP, SPEED_FLOOR);
    send_same(SPEED_FLOOR, SPEED_TOP);
    send_item({speed_t'(100), speed_t'(-1), speed_t'(1), speed_t'(0)},
              {speed_t'(100), speed_t'(-1), speed_t'(0), speed_t'(1)});
    send_same(SPEED_BOTTOM, '0);
    repeat (3) send_same(speed_t'(900), speed_t'(1000));
    repeat (4) send_same(SPEED_TOP, speed_t'(5));
    send_same(speed_t'(-700), speed_t'(-300));
    send_same(speed_t'(17'h0AAAA), speed_t'(17'h15555));
    send_same(speed_t'(17'h15555), speed_t'(17'h0AAAA));

    drain();
    program_regs('0, '0, '0, '0, '0, 1'b0);
    random_run(120);

    drain();
    program_regs(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
    random_run(300);

    drain();
    program_random(1'b1);
    random_run(500);

    drain();
    program_random(1'b1);
    random_run(450);

    drain();
    steady = 1'b1;
    program_random(1'b0);
    random_run(400);

    // push the integrators hard: wheels 0 and 1 up, wheels 2 and 3 down
    drain();
    program_regs(CFG_DATA_W'($urandom_range(0, 4095)), CFG_DATA_W'($urandom_range(0, 4095)),
                 CFG_DATA_W'($urandom_range(0, 4095)),
                 CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b0);
    for (int k = 0; k < SOAK_ITEMS; k++)
      send_item({SPEED_TOP, SPEED_TOP, SPEED_FLOOR, SPEED_FLOOR},
                {SPEED_FLOOR, SPEED_FLOOR, SPEED_TOP, SPEED_TOP});
    steady = 1'b0;
    random_run(40);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fwpid_pkg.sv
rtl/four_wheel_pid_speed_control.sv
tb/fwpid_drive_checker.sv
tb/tb_four_wheel_pid_speed_control.sv
